// ===== src/itp_pkg.sv =====
// ---------------------------------------------------------------------------
// ISO-TP reassembler package
// Shared types, codes and constants of the transport receive block.
// ---------------------------------------------------------------------------
package itp_pkg;

  // Queue between the classifier and the message engine.
  localparam int unsigned ITP_QDEPTH = 2;

  localparam logic [15:0] START_TIMEOUT_RESET = 16'd1000;

  // Configuration register indexes (word address).
  localparam logic [1:0] REG_ID_FILTER     = 2'd0;
  localparam logic [1:0] REG_START_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_FC_ID         = 2'd2;

  typedef enum logic [1:0] {
    KIND_SINGLE,
    KIND_FIRST,
    KIND_CONSEC,
    KIND_OTHER
  } itp_kind_e;

  typedef enum logic [2:0] {
    ST_PROGRESS = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_TIMEOUT  = 3'd2,
    ST_BAD      = 3'd3,
    ST_NOSTART  = 3'd4
  } itp_status_e;

  // Classified request as held in the queue. data[0] is frame byte 1.
  typedef struct packed {
    logic             is_tick;
    logic             pass;
    itp_kind_e        kind;
    logic [3:0]       nib;
    logic [6:0][7:0]  data;
  } itp_item_t;

  typedef struct packed {
    itp_status_e      status;
    logic             fc;
    logic [11:0]      offset;
    logic [2:0]       count;
    logic [11:0]      total;
    logic [6:0][7:0]  bytes;
  } itp_result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } itp_qstat_t;

endpackage

// ===== src/itp_front.sv =====
// ---------------------------------------------------------------------------
// ISO-TP front end
// Accepts input requests, applies the identifier filter and decodes the PCI.
// ---------------------------------------------------------------------------
module itp_front (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 mode_i,
  input  logic [28:0]          frame_id_i,
  input  logic [7:0]           byte0_i,
  input  logic [7:0]           byte1_i,
  input  logic [7:0]           byte2_i,
  input  logic [7:0]           byte3_i,
  input  logic [7:0]           byte4_i,
  input  logic [7:0]           byte5_i,
  input  logic [7:0]           byte6_i,
  input  logic [7:0]           byte7_i,
  input  logic [28:0]          id_filter_i,
  input  itp_pkg::itp_qstat_t  q_stat_i,
  output logic                 push_o,
  output itp_pkg::itp_item_t   item_o
);
  import itp_pkg::*;

  itp_kind_e kind;

  always_comb begin
    unique case (byte0_i[7:4])
      4'h0:    kind = KIND_SINGLE;
      4'h1:    kind = KIND_FIRST;
      4'h2:    kind = KIND_CONSEC;
      default: kind = KIND_OTHER;
    endcase
  end

  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  always_comb begin
    item_o.is_tick = mode_i;
    // A zero filter lets every identifier through.
    item_o.pass    = (id_filter_i == 29'd0) || (frame_id_i == id_filter_i);
    item_o.kind    = kind;
    item_o.nib     = byte0_i[3:0];
    item_o.data    = {byte7_i, byte6_i, byte5_i, byte4_i, byte3_i, byte2_i, byte1_i};
  end

endmodule

// ===== src/itp_queue.sv =====
// ---------------------------------------------------------------------------
// ISO-TP request queue
// Short FIFO of classified requests between the front end and the engine.
// ---------------------------------------------------------------------------
module itp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  itp_pkg::itp_item_t   item_i,
  input  logic                 pop_i,
  output logic                 valid_o,
  output itp_pkg::itp_item_t   item_o,
  output itp_pkg::itp_qstat_t  stat_o
);
  import itp_pkg::*;

  localparam int unsigned PtrW = $clog2(ITP_QDEPTH);
  localparam int unsigned CntW = $clog2(ITP_QDEPTH + 1);

  itp_item_t       mem_q [ITP_QDEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o       = mem_q[rd_ptr_q];
  assign valid_o      = (cnt_q != '0);
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CntW'(ITP_QDEPTH));

endmodule

// ===== src/itp_engine.sv =====
// ---------------------------------------------------------------------------
// ISO-TP message engine
// Carries out queued requests against the message state and registers the
// result for the output channel.
// ---------------------------------------------------------------------------
module itp_engine #(
  parameter int MAX_PAYLOAD         = 4095,
  parameter int START_ATTEMPT_LIMIT = 10,
  parameter int FRAME_TIMEOUT_MS    = 1000
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  itp_pkg::itp_item_t   item_i,
  output logic                 pop_o,
  input  logic [15:0]          start_timeout_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output itp_pkg::itp_result_t result_o
);
  import itp_pkg::*;

  typedef struct packed {
    logic        in_msg;
    logic [3:0]  attempts;
    logic [15:0] wait_cnt;
    logic [3:0]  seq;
    logic [11:0] done;
    logic [11:0] len;
  } eng_state_t;

  localparam eng_state_t IdleState = '{in_msg: 1'b0, attempts: 4'd0, wait_cnt: 16'd0,
                                       seq: 4'd1, done: 12'd0, len: 12'd0};

  eng_state_t  st_q, st_d;
  logic        out_valid_q, out_valid_d;
  itp_result_t res_q, res_d;
  logic        emit;

  logic [15:0] wait_inc;
  logic [15:0] idle_limit;
  logic [11:0] remain;
  logic [2:0]  chunk;
  logic [11:0] done_sum;
  logic [11:0] first_total;
  logic [2:0]  single_len;
  logic [3:0]  attempts_inc;
  logic [6:0][7:0] src_first;

  function automatic logic [6:0][7:0] mask_bytes(logic [6:0][7:0] src, logic [2:0] cnt);
    logic [6:0][7:0] r;
    for (int i = 0; i < 7; i++) begin
      r[i] = (3'(i) < cnt) ? src[i] : 8'd0;
    end
    return r;
  endfunction

  assign pop_o        = item_valid_i && (!out_valid_q || out_ready_i);
  assign wait_inc     = (st_q.wait_cnt == 16'hFFFF) ? st_q.wait_cnt : st_q.wait_cnt + 16'd1;
  assign idle_limit   = (start_timeout_i == 16'd0) ? 16'd1 : start_timeout_i;
  assign remain       = st_q.len - st_q.done;
  assign chunk        = (remain > 12'd7) ? 3'd7 : remain[2:0];
  assign done_sum     = st_q.done + {9'd0, chunk};
  assign first_total  = {item_i.nib, item_i.data[0]};
  assign single_len   = (item_i.nib > 4'd7) ? 3'd7 : item_i.nib[2:0];
  assign attempts_inc = st_q.attempts + 4'd1;
  // A first frame carries its payload from frame byte 2 onwards.
  assign src_first    = {8'd0, item_i.data[6:1]};

  always_comb begin
    st_d  = st_q;
    res_d = '0;
    emit  = 1'b0;
    if (pop_o) begin
      if (item_i.is_tick) begin
        st_d.wait_cnt = wait_inc;
        if (st_q.in_msg ? (wait_inc >= 16'(FRAME_TIMEOUT_MS)) : (wait_inc >= idle_limit)) begin
          emit         = 1'b1;
          res_d.status = ST_TIMEOUT;
          res_d.total  = st_q.in_msg ? st_q.len : 12'd0;
          st_d         = IdleState;
        end
      end else begin
        st_d.wait_cnt = 16'd0;
        if (st_q.in_msg) begin
          // Frames for other identifiers are ignored while a message is open.
          if (item_i.pass) begin
            emit = 1'b1;
            if (item_i.kind != KIND_CONSEC || item_i.nib != st_q.seq) begin
              res_d.status = ST_BAD;
              res_d.total  = st_q.len;
              st_d         = IdleState;
            end else begin
              res_d.offset = st_q.done;
              res_d.count  = chunk;
              res_d.total  = st_q.len;
              res_d.bytes  = mask_bytes(item_i.data, chunk);
              if (done_sum >= st_q.len) begin
                res_d.status = ST_COMPLETE;
                st_d         = IdleState;
              end else begin
                res_d.status = ST_PROGRESS;
                st_d.done    = done_sum;
                st_d.seq     = st_q.seq + 4'd1;
              end
            end
          end
        end else if (item_i.pass && item_i.kind == KIND_SINGLE) begin
          emit         = 1'b1;
          res_d.status = ST_COMPLETE;
          res_d.count  = single_len;
          res_d.total  = {9'd0, single_len};
          res_d.bytes  = mask_bytes(item_i.data, single_len);
          st_d         = IdleState;
        end else if (item_i.pass && item_i.kind == KIND_FIRST) begin
          emit = 1'b1;
          st_d = IdleState;
          if (first_total > 12'(MAX_PAYLOAD)) begin
            res_d.status = ST_BAD;
          end else if (first_total <= 12'd6) begin
            res_d.status = ST_COMPLETE;
            res_d.fc     = 1'b1;
            res_d.count  = first_total[2:0];
            res_d.total  = first_total;
            res_d.bytes  = mask_bytes(src_first, first_total[2:0]);
          end else begin
            res_d.status = ST_PROGRESS;
            res_d.fc     = 1'b1;
            res_d.count  = 3'd6;
            res_d.total  = first_total;
            res_d.bytes  = src_first;
            st_d.in_msg  = 1'b1;
            st_d.len     = first_total;
            st_d.done    = 12'd6;
          end
        end else begin
          if (attempts_inc >= 4'(START_ATTEMPT_LIMIT)) begin
            emit         = 1'b1;
            res_d.status = ST_NOSTART;
            st_d         = IdleState;
          end else begin
            st_d.attempts = attempts_inc;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= IdleState;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

// ===== src/iso_tp_reassembler_top.sv =====
// ---------------------------------------------------------------------------
// ISO-TP reassembler top level
// Receive side of ISO 15765-2: reassembles messages from CAN frames and
// streams their payload in chunks of up to seven bytes.
// ---------------------------------------------------------------------------
// Usage:
// The input channel carries one request per transfer: a received CAN frame
// (mode 0) or a one millisecond tick (mode 1). Each request gives zero or one
// result on the output channel; a result carries a status, a flow-control
// request flag, the chunk offset and count, the message length and seven
// payload bytes (bytes past the count are zero).
// Throughput is one request per clock while the receiver takes results.
// An accepted request enters the queue; the message engine then carries
// it out and registers its result, offered until taken. A two-entry queue
// separates the classifier from the engine; when the receiver stalls, the
// registered result holds, the queue fills and in_ready_o falls after two
// further requests. After reset the block waits for a start frame with
// all counters clear, id_filter 0, start_timeout_ms 1000 and flow_control_id
// 0. The user must write the registers over the APB port only while the
// block is idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module iso_tp_reassembler_top #(
  parameter int MAX_PAYLOAD         = 4095,
  parameter int START_ATTEMPT_LIMIT = 10,
  parameter int FRAME_TIMEOUT_MS    = 1000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [28:0] frame_id_i,
  input  logic [7:0]  byte0_i,
  input  logic [7:0]  byte1_i,
  input  logic [7:0]  byte2_i,
  input  logic [7:0]  byte3_i,
  input  logic [7:0]  byte4_i,
  input  logic [7:0]  byte5_i,
  input  logic [7:0]  byte6_i,
  input  logic [7:0]  byte7_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        send_flow_control_o,
  output logic [11:0] chunk_offset_o,
  output logic [2:0]  chunk_count_o,
  output logic [11:0] total_length_o,
  output logic [7:0]  out0_o,
  output logic [7:0]  out1_o,
  output logic [7:0]  out2_o,
  output logic [7:0]  out3_o,
  output logic [7:0]  out4_o,
  output logic [7:0]  out5_o,
  output logic [7:0]  out6_o
);
  import itp_pkg::*;

  logic [28:0] id_filter_q, id_filter_d;
  logic [15:0] start_timeout_q, start_timeout_d;
  logic [28:0] fc_id_q, fc_id_d;
  logic        cfg_wr;

  logic        push;
  logic        pop;
  logic        q_valid;
  itp_item_t   push_item;
  itp_item_t   q_item;
  itp_qstat_t  q_stat;
  itp_result_t result;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    id_filter_d     = id_filter_q;
    start_timeout_d = start_timeout_q;
    fc_id_d         = fc_id_q;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ID_FILTER:     id_filter_d     = pwdata[28:0];
        REG_START_TIMEOUT: start_timeout_d = pwdata[15:0];
        REG_FC_ID:         fc_id_d         = pwdata[28:0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_filter_q     <= 29'd0;
      start_timeout_q <= START_TIMEOUT_RESET;
      fc_id_q         <= 29'd0;
    end else begin
      id_filter_q     <= id_filter_d;
      start_timeout_q <= start_timeout_d;
      fc_id_q         <= fc_id_d;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ID_FILTER:     prdata = {3'd0, id_filter_q};
      REG_START_TIMEOUT: prdata = {16'd0, start_timeout_q};
      REG_FC_ID:         prdata = {3'd0, fc_id_q};
      default:           prdata = 32'd0;
    endcase
  end

  itp_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .frame_id_i  (frame_id_i),
    .byte0_i     (byte0_i),
    .byte1_i     (byte1_i),
    .byte2_i     (byte2_i),
    .byte3_i     (byte3_i),
    .byte4_i     (byte4_i),
    .byte5_i     (byte5_i),
    .byte6_i     (byte6_i),
    .byte7_i     (byte7_i),
    .id_filter_i (id_filter_q),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .item_o      (push_item)
  );

  itp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item),
    .stat_o  (q_stat)
  );

  itp_engine #(
    .MAX_PAYLOAD         (MAX_PAYLOAD),
    .START_ATTEMPT_LIMIT (START_ATTEMPT_LIMIT),
    .FRAME_TIMEOUT_MS    (FRAME_TIMEOUT_MS)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (q_valid),
    .item_i          (q_item),
    .pop_o           (pop),
    .start_timeout_i (start_timeout_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_o        (result)
  );

  assign status_o            = result.status;
  assign send_flow_control_o = result.fc;
  assign chunk_offset_o      = result.offset;
  assign chunk_count_o       = result.count;
  assign total_length_o      = result.total;
  assign out0_o              = result.bytes[0];
  assign out1_o              = result.bytes[1];
  assign out2_o              = result.bytes[2];
  assign out3_o              = result.bytes[3];
  assign out4_o              = result.bytes[4];
  assign out5_o              = result.bytes[5];
  assign out6_o              = result.bytes[6];

  // An accepted request is always waiting in the queue on the next cycle.
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !q_stat.empty)
    else $error("accepted request missing from queue");

  a_queue_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty");

  a_error_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_TIMEOUT || status_o == ST_BAD || status_o == ST_NOSTART)
    |-> chunk_count_o == 3'd0 && !send_flow_control_o && chunk_offset_o == 12'd0)
    else $error("error result carries payload");

  a_fc_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_flow_control_o
    |-> chunk_offset_o == 12'd0 && (status_o == ST_PROGRESS || status_o == ST_COMPLETE))
    else $error("flow control request outside a first frame");

endmodule
